/* rtl/prr_pkg.sv */
// Shared types and constants for the process slot round-robin scheduler.
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;

    localparam int IN_BITS    = CMD_W + SLOT_W + ID_W;
    localparam int OUT_BITS   = STATUS_W + SLOT_W + ID_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [ID_W-1:0] FIRST_ID = ID_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE   = 3'd0,
        CMD_FREE     = 3'd1,
        CMD_SLEEP    = 3'd2,
        CMD_WAKE     = 3'd3,
        CMD_SCHEDULE = 3'd4,
        CMD_FIND     = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_NONE     = 3'd2,
        STS_NOTFOUND = 3'd3,
        STS_EMPTY    = 3'd4
    } status_t;

    // Where the id of a pending result comes from.
    typedef enum logic [1:0] {
        ID_ZERO = 2'd0,
        ID_RAM  = 2'd1,
        ID_PEND = 2'd2
    } id_src_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic load_out;
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic in_find;
        logic scan_done;
        logic out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

/* rtl/process_slot_round_robin_scheduler_core.sv */
// Top level of the process slot round-robin scheduler.
//
//   channel | dir | tdata fields, lowest bit first
//   --------+-----+-----------------------------------------------
//   s_      | in  | cmd[2:0], slot[6:3], query_id[22:7], zero[23]
//   m_      | out | status[2:0], result_slot[6:3], result_id[22:7], zero[23]
//
// Create, free, sleep, wake, schedule and unknown commands go from the transfer
// straight to the result state: the transfer updates the slot marks and writes
// or reads the id store, and the result state loads the output register once it
// is free. Find first sweeps the id store one slot a cycle. A stalled m_ channel
// holds the result stage and with it s_tready. Reset is synchronous on aresetn
// and clears all slot marks; next_id returns to one.
`timescale 1ns / 1ps
`default_nettype none

module process_slot_round_robin_scheduler_core
    import prr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // cmd, slot, query_id
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata    // status, result_slot, result_id
);

    ctl_cmd_t ctl_cmd;
    ctl_sts_t ctl_sts;

    prr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    prr_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (ctl_cmd),
        .sts      (ctl_sts)
    );

endmodule

`default_nettype wire

/* rtl/prr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/prr_ctrl.sv */
// Control state machine: accept, id search sweep, result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module prr_ctrl
    import prr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.in_find ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // hold until the output register can take the result
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> !s_tready)
        else $error("input taken again right after a transfer");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) && !sts.out_free |=> (state_reg == ST_RESULT))
        else $error("result dropped while output busy");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && sts.scan_done |=> (state_reg == ST_RESULT))
        else $error("search did not hand over its result");

endmodule

`default_nettype wire

/* rtl/prr_dp.sv */
// Datapath: slot marks, id store, selection logic and output register.
`timescale 1ns / 1ps
`default_nettype none

module prr_dp
    import prr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire ctl_cmd_t             cmd,
    output ctl_sts_t                  sts
);

    localparam int SW = $clog2(SLOTS);

    logic [SLOTS-1:0] occ_reg, occ_next;
    logic [SLOTS-1:0] run_reg, run_next;
    logic [SLOTS-1:0] srv_reg, srv_next;
    logic [ID_W-1:0]  next_id_reg, next_id_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [SW-1:0]    cur_idx_reg, cur_idx_next;

    logic [SW-1:0]    scan_reg, scan_next;
    logic [ID_W-1:0]  query_reg, query_next;

    status_t          pend_status_reg, pend_status_next;
    logic [SW-1:0]    pend_slot_reg, pend_slot_next;
    logic [ID_W-1:0]  pend_id_reg, pend_id_next;
    id_src_t          pend_src_reg, pend_src_next;

    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [ID_W-1:0]  out_id_reg;

    cmd_t             in_cmd;
    logic [SLOT_W-1:0] in_slot;
    logic [ID_W-1:0]  in_query;

    logic [SW-1:0]    tgt;
    logic             tgt_ok;
    logic             free_any;
    logic [SW-1:0]    free_idx;
    logic [SLOTS-1:0] ready_vec, cand_vec, sel_vec;
    logic             rdy_any;
    logic [SW-1:0]    pick_idx;
    logic [SLOTS-1:0] one_slot;

    logic             ram_we;
    logic             ram_re;
    logic [SW-1:0]    ram_raddr;
    logic [ID_W-1:0]  ram_rdata;

    logic             scan_hit;
    logic             scan_last;
    logic [ID_W-1:0]  id_sel;

    assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_slot  = s_tdata[CMD_W +: SLOT_W];
    assign in_query = s_tdata[CMD_W + SLOT_W +: ID_W];

    assign tgt    = SW'(in_slot);
    assign tgt_ok = (32'(in_slot) < SLOTS) && occ_reg[tgt];

    assign ready_vec = occ_reg & run_reg;
    assign cand_vec  = ready_vec & ~srv_reg;
    // start a new round when every runnable slot has been served
    assign sel_vec   = (cand_vec != '0) ? cand_vec : ready_vec;
    assign rdy_any   = (ready_vec != '0);
    assign free_any  = (~occ_reg != '0);

    always_comb begin
        free_idx = '0;
        pick_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                free_idx = SW'(i);
            end
            if (sel_vec[i]) begin
                pick_idx = SW'(i);
            end
        end
    end

    assign one_slot = {{(SLOTS-1){1'b0}}, 1'b1} << pick_idx;

    assign scan_hit  = occ_reg[scan_reg] && (ram_rdata == query_reg);
    assign scan_last = (scan_reg == SW'(SLOTS - 1));

    assign sts.in_find   = (in_cmd == CMD_FIND);
    assign sts.scan_done = scan_hit || scan_last;
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_comb begin
        occ_next         = occ_reg;
        run_next         = run_reg;
        srv_next         = srv_reg;
        next_id_next     = next_id_reg;
        cur_valid_next   = cur_valid_reg;
        cur_idx_next     = cur_idx_reg;
        scan_next        = scan_reg;
        query_next       = query_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_id_next     = pend_id_reg;
        pend_src_next    = pend_src_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = tgt;

        if (cmd.accept) begin
            pend_status_next = STS_OK;
            pend_slot_next   = '0;
            pend_src_next    = ID_ZERO;
            case (in_cmd)
                CMD_CREATE: begin
                    if (free_any) begin
                        occ_next[free_idx] = 1'b1;
                        run_next[free_idx] = 1'b1;
                        srv_next[free_idx] = 1'b0;
                        ram_we             = 1'b1;
                        pend_slot_next     = free_idx;
                        pend_id_next       = next_id_reg;
                        pend_src_next      = ID_PEND;
                        next_id_next       = next_id_reg + ID_W'(1);
                    end else begin
                        pend_status_next = STS_FULL;
                    end
                end
                CMD_FREE: begin
                    if (tgt_ok) begin
                        occ_next[tgt] = 1'b0;
                        run_next[tgt] = 1'b0;
                        srv_next[tgt] = 1'b0;
                        if (cur_valid_reg && (cur_idx_reg == tgt)) begin
                            cur_valid_next = 1'b0;
                        end
                        ram_re         = 1'b1;
                        pend_slot_next = tgt;
                        pend_src_next  = ID_RAM;
                    end else begin
                        pend_status_next = STS_EMPTY;
                    end
                end
                CMD_SLEEP, CMD_WAKE: begin
                    if (tgt_ok) begin
                        run_next[tgt]  = (in_cmd == CMD_WAKE);
                        ram_re         = 1'b1;
                        pend_slot_next = tgt;
                        pend_src_next  = ID_RAM;
                    end else begin
                        pend_status_next = STS_EMPTY;
                    end
                end
                CMD_SCHEDULE: begin
                    if (rdy_any) begin
                        srv_next       = ((cand_vec != '0) ? srv_reg : '0) | one_slot;
                        cur_valid_next = 1'b1;
                        cur_idx_next   = pick_idx;
                        ram_re         = 1'b1;
                        ram_raddr      = pick_idx;
                        pend_slot_next = pick_idx;
                        pend_src_next  = ID_RAM;
                    end else begin
                        pend_status_next = STS_NONE;
                    end
                end
                CMD_FIND: begin
                    scan_next  = '0;
                    query_next = in_query;
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                end
                default: begin
                    pend_status_next = STS_OK;
                end
            endcase
        end else if (cmd.scan_step) begin
            if (scan_hit) begin
                pend_status_next = STS_OK;
                pend_slot_next   = scan_reg;
                pend_id_next     = ram_rdata;
                pend_src_next    = ID_PEND;
            end else if (scan_last) begin
                pend_status_next = STS_NOTFOUND;
                pend_slot_next   = '0;
                pend_src_next    = ID_ZERO;
            end else begin
                // advance the sweep one slot
                scan_next = scan_reg + SW'(1);
                ram_re    = 1'b1;
                ram_raddr = scan_reg + SW'(1);
            end
        end
    end

    prr_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_id_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (next_id_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        case (pend_src_reg)
            ID_RAM:  id_sel = ram_rdata;
            ID_PEND: id_sel = pend_id_reg;
            default: id_sel = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= '0;
            run_reg       <= '0;
            srv_reg       <= '0;
            next_id_reg   <= FIRST_ID;
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            occ_reg       <= occ_next;
            run_reg       <= run_next;
            srv_reg       <= srv_next;
            next_id_reg   <= next_id_next;
            cur_valid_reg <= cur_valid_next;
            cur_idx_reg   <= cur_idx_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg        <= scan_next;
        query_reg       <= query_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_id_reg     <= pend_id_next;
        pend_src_reg    <= pend_src_next;
        if (cmd.load_out) begin
            out_status_reg <= pend_status_reg;
            out_slot_reg   <= SLOT_W'(pend_slot_reg);
            out_id_reg     <= id_sel;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_BITS){1'b0}}, out_id_reg, out_slot_reg,
                       out_status_reg};

    a_marks_need_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ((run_reg | srv_reg) & ~occ_reg) == '0)
        else $error("runnable or served mark on a free slot");

    a_current_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> occ_reg[cur_idx_reg])
        else $error("current slot points at a free slot");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

/* tb/sv/process_slot_round_robin_scheduler_core_tb.sv */
// Testbench for the process slot round-robin scheduler: directed and random commands.
`timescale 1ns / 1ps

module process_slot_round_robin_scheduler_core_tb;
    import prr_pkg::*;

    localparam int NSLOTS      = SLOTS_DEF;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int RANDOM_ITEMS_PER_PHASE = 175;
    localparam int PRINT_CAP   = 60;

    // Command codes that the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
    } sched_result_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    process_slot_round_robin_scheduler_core #(.SLOTS(NSLOTS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow of the slot table.
    logic            occ   [NSLOTS];
    logic            ready [NSLOTS];
    logic            served[NSLOTS];
    logic [ID_W-1:0] pid   [NSLOTS];
    logic [ID_W-1:0] next_pid;
    logic            running_valid;
    int              running_slot;

    sched_result_t pending_results[$];

    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int err_count = 0;
    int items_sent = 0;
    int directed_items = 0;
    int results_checked = 0;
    int status_seen[5];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, msg);
        err_count++;
    endtask

    function automatic int lowest_pick();
        for (int i = 0; i < NSLOTS; i++)
            if (occ[i] && ready[i] && !served[i]) return i;
        return -1;
    endfunction

    function automatic sched_result_t compute_result(input logic [CMD_W-1:0] cmd,
                                                     input logic [SLOT_W-1:0] slot,
                                                     input logic [ID_W-1:0] qid);
        sched_result_t r;
        int k;
        logic any_ready;
        r = '{status: STS_OK, slot: '0, id: '0};
        case (cmd)
            CMD_CREATE: begin
                r.status = STS_FULL;
                for (int i = 0; i < NSLOTS; i++) begin
                    if (!occ[i] && r.status == STS_FULL) begin
                        occ[i] = 1'b1;
                        ready[i] = 1'b1;
                        served[i] = 1'b0;
                        pid[i] = next_pid;
                        next_pid = next_pid + 1'b1;
                        r = '{status: STS_OK, slot: SLOT_W'(i), id: pid[i]};
                    end
                end
            end
            CMD_FREE, CMD_SLEEP, CMD_WAKE: begin
                if (int'(slot) >= NSLOTS || !occ[slot]) begin
                    r.status = STS_EMPTY;
                end else begin
                    r = '{status: STS_OK, slot: slot, id: pid[slot]};
                    if (cmd == CMD_FREE) begin
                        occ[slot] = 1'b0;
                        ready[slot] = 1'b0;
                        served[slot] = 1'b0;
                        if (running_valid && running_slot == int'(slot))
                            running_valid = 1'b0;
                    end else begin
                        ready[slot] = (cmd == CMD_WAKE);
                    end
                end
            end
            CMD_SCHEDULE: begin
                any_ready = 1'b0;
                for (int i = 0; i < NSLOTS; i++)
                    if (occ[i] && ready[i]) any_ready = 1'b1;
                if (!any_ready) begin
                    r.status = STS_NONE;
                end else begin
                    k = lowest_pick();
                    // Round finished: clear the served marks and pick again.
                    if (k < 0) begin
                        for (int i = 0; i < NSLOTS; i++) served[i] = 1'b0;
                        k = lowest_pick();
                    end
                    served[k] = 1'b1;
                    running_valid = 1'b1;
                    running_slot = k;
                    r = '{status: STS_OK, slot: SLOT_W'(k), id: pid[k]};
                end
            end
            CMD_FIND: begin
                r.status = STS_NOTFOUND;
                for (int i = NSLOTS - 1; i >= 0; i--)
                    if (occ[i] && pid[i] == qid)
                        r = '{status: STS_OK, slot: SLOT_W'(i), id: pid[i]};
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                            input logic [ID_W-1:0] qid);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({qid, slot, cmd});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(compute_result(cmd, slot, qid));
        items_sent++;
    endtask

    always @(posedge aclk) begin
        sched_result_t want;
        sched_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[2:0];
            got.slot   = m_tdata[6:3];
            got.id     = m_tdata[22:7];
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: status %0d slot %0d id %0d",
                                          got.status, got.slot, got.id));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.status < 5) status_seen[want.status]++;
                if (got.status !== want.status)
                    report_mismatch($sformatf("status: got %0d want %0d",
                                              got.status, want.status));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("result_slot: got %0d want %0d",
                                              got.slot, want.slot));
                if (got.id !== want.id)
                    report_mismatch($sformatf("result_id: got %0h want %0h", got.id, want.id));
            end
        end
    end

    // Pick a slot that is mostly a live one, so free, sleep and wake get past the check.
    function automatic logic [SLOT_W-1:0] choose_slot();
        int live[$];
        for (int i = 0; i < NSLOTS; i++)
            if (occ[i]) live.push_back(i);
        if (live.size() != 0 && $urandom_range(99) < 80)
            return SLOT_W'(live[$urandom_range(live.size() - 1)]);
        return SLOT_W'($urandom_range(NSLOTS - 1));
    endfunction

    function automatic logic [ID_W-1:0] choose_query();
        int live[$];
        for (int i = 0; i < NSLOTS; i++)
            if (occ[i]) live.push_back(i);
        if (live.size() != 0 && $urandom_range(99) < 65)
            return pid[live[$urandom_range(live.size() - 1)]];
        if ($urandom_range(1)) return next_pid;
        return ID_W'($urandom_range(16'hFFFF));
    endfunction

    task automatic test_empty_table();
        send_cmd(CMD_SCHEDULE, '0, '0);
        send_cmd(CMD_SLEEP, '0, '0);
    endtask

    task automatic test_fill_table();
        // One more than the table holds, so the last one reports full.
        for (int i = 0; i <= NSLOTS; i++) send_cmd(CMD_CREATE, SLOT_W'(i), '1);
    endtask

    task automatic test_find();
        send_cmd(CMD_FIND, '0, ID_W'(NSLOTS));
        send_cmd(CMD_FIND, '1, 16'hFFFF);
    endtask

    task automatic test_sleep_wake();
        send_cmd(CMD_SLEEP, SLOT_W'(NSLOTS - 1), '0);
        send_cmd(CMD_WAKE, SLOT_W'(NSLOTS - 1), '0);
    endtask

    task automatic test_schedule_and_free();
        // Free the slot that was just scheduled.
        send_cmd(CMD_SCHEDULE, '1, '0);
        send_cmd(CMD_FREE, '0, '0);
    endtask

    task automatic test_unknown_cmd();
        send_cmd(CMD_UNUSED_HI, '1, '1);
    endtask

    task automatic test_random_traffic(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 17)      send_cmd(CMD_CREATE, SLOT_W'($urandom), ID_W'($urandom));
            else if (pick < 31) send_cmd(CMD_FREE, choose_slot(), ID_W'($urandom));
            else if (pick < 44) send_cmd(CMD_SLEEP, choose_slot(), ID_W'($urandom));
            else if (pick < 57) send_cmd(CMD_WAKE, choose_slot(), ID_W'($urandom));
            else if (pick < 80) send_cmd(CMD_SCHEDULE, SLOT_W'($urandom), ID_W'($urandom));
            else if (pick < 95) send_cmd(CMD_FIND, SLOT_W'($urandom), choose_query());
            else send_cmd($urandom_range(1) ? CMD_UNUSED_LO : CMD_UNUSED_HI,
                          SLOT_W'($urandom), ID_W'($urandom));
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // Allow for a late result from a full sweep of the id store.
        repeat (NSLOTS + 8) @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < NSLOTS; i++) begin
            occ[i] = 1'b0;
            ready[i] = 1'b0;
            served[i] = 1'b0;
            pid[i] = '0;
        end
        for (int i = 0; i < 5; i++) status_seen[i] = 0;
        next_pid = FIRST_ID;
        running_valid = 1'b0;
        running_slot = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        s_idle_pct = 27;
        m_idle_pct = 47;
        test_empty_table();
        test_fill_table();
        test_find();
        test_sleep_wake();
        test_schedule_and_free();
        test_unknown_cmd();
        directed_items = items_sent;

        test_random_traffic(RANDOM_ITEMS_PER_PHASE);
        s_idle_pct = 47;
        m_idle_pct = 27;
        test_random_traffic(RANDOM_ITEMS_PER_PHASE);
        s_idle_pct = 0;
        m_idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS_PER_PHASE);
        wait_drain();

        $display("Covered %0d commands (%0d directed) under three idle mixes, %0d results checked",
                 items_sent, directed_items, results_checked);
        $display("Status mix: ok %0d, full %0d, none %0d, not found %0d, empty %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, pending_results.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
